// ===== hdl/ds402_pkg.sv =====
// Shared types, status/control word codes and register indexes for the
// drive enable sequencer with slew-limited velocity command.
// No dependencies.
package ds402_pkg;

  // Status word decode
  localparam logic [15:0] FAULT_BIT   = 16'h0008;
  localparam logic [15:0] STATE_MASK  = 16'h006F;
  localparam logic [15:0] ST_DISABLED = 16'h0060;
  localparam logic [15:0] ST_NOT_RDY  = 16'h0040;
  localparam logic [15:0] ST_READY    = 16'h0021;
  localparam logic [15:0] ST_SW_ON    = 16'h0023;
  localparam logic [15:0] ST_OP_EN    = 16'h0027;

  // Control words
  localparam logic [15:0] CW_NONE        = 16'h0000;
  localparam logic [15:0] CW_RESET_PULSE = 16'h0080;
  localparam logic [15:0] CW_SHUTDOWN    = 16'h0006;
  localparam logic [15:0] CW_SWITCH_ON   = 16'h0007;
  localparam logic [15:0] CW_ENABLE_OP   = 16'h000F;

  // Drive state codes
  localparam logic [2:0] DS_FAULT    = 3'd0;
  localparam logic [2:0] DS_DISABLED = 3'd1;
  localparam logic [2:0] DS_READY    = 3'd2;
  localparam logic [2:0] DS_SW_ON    = 3'd3;
  localparam logic [2:0] DS_OP_EN    = 3'd4;
  localparam logic [2:0] DS_OTHER    = 3'd5;

  // Configuration register indexes and reset values
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 20;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_STEP    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_TICK  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FAULT_PER   = 2'd2;
  localparam logic [19:0] MAX_STEP_RST   = 20'd80;
  localparam logic [7:0]  PULSE_TICK_RST = 8'd8;
  localparam logic [7:0]  FAULT_PER_RST  = 8'd16;

  localparam logic [15:0] TALLY_MAX = 16'hFFFF;

  typedef struct packed {
    logic        [15:0] drive_status;
    logic signed [31:0] target_velocity;
  } in_item_t;

  typedef struct packed {
    logic        [15:0] drive_control;
    logic signed [31:0] velocity_command;
    logic        [2:0]  drive_state;
    logic        [15:0] fault_events;
  } out_item_t;

  typedef struct packed {
    logic [19:0] max_step;
    logic [7:0]  reset_pulse_tick;
    logic [7:0]  fault_period;
  } cfg_t;

  typedef struct packed {
    logic        [7:0]  fault_step;
    logic signed [31:0] command_reg;
    logic               enabled_flag;
    logic        [15:0] fault_tally;
  } seq_state_t;

endpackage

// ===== hdl/ds402_step.sv =====
// Per-tick decode, fault-reset sequencing and velocity slew clamp.
// Pure combinational; depends on ds402_pkg.
module ds402_step import ds402_pkg::*; (
  input  cfg_t       cfg,
  input  seq_state_t state,
  input  in_item_t   item,
  output seq_state_t state_next,
  output out_item_t  result
);

  logic        [8:0]  step_inc;
  logic        [15:0] masked;
  logic signed [32:0] delta;
  logic signed [32:0] lim;
  logic signed [32:0] cmd_up;
  logic signed [32:0] cmd_dn;
  logic signed [31:0] slewed;
  logic        [15:0] cw;
  logic        [2:0]  ds;

  assign step_inc = {1'b0, state.fault_step} + 9'd1;
  assign masked   = item.drive_status & STATE_MASK;

  // The clamped result always lies between the old command and the target,
  // so the 33-bit sums truncate back to 32 bits without loss.
  assign delta  = {item.target_velocity[31], item.target_velocity}
                - {state.command_reg[31], state.command_reg};
  assign lim    = {13'd0, cfg.max_step};
  assign cmd_up = {state.command_reg[31], state.command_reg} + lim;
  assign cmd_dn = {state.command_reg[31], state.command_reg} - lim;

  always_comb begin
    if (delta > lim) begin
      slewed = cmd_up[31:0];
    end else if (delta < -lim) begin
      slewed = cmd_dn[31:0];
    end else begin
      slewed = item.target_velocity;
    end
  end

  always_comb begin
    state_next = state;
    cw = CW_NONE;
    ds = DS_OTHER;
    if ((item.drive_status & FAULT_BIT) != 16'd0) begin
      ds = DS_FAULT;
      if (state.enabled_flag && state.fault_tally != TALLY_MAX) begin
        state_next.fault_tally = state.fault_tally + 16'd1;
      end
      state_next.enabled_flag = 1'b0;
      state_next.command_reg  = '0;
      state_next.fault_step   = step_inc[7:0];
      priority if (step_inc < {1'b0, cfg.reset_pulse_tick}) begin
        cw = CW_NONE;
      end else if (step_inc == {1'b0, cfg.reset_pulse_tick}) begin
        cw = CW_RESET_PULSE;
      end else begin
        cw = CW_NONE;
        if (step_inc > {1'b0, cfg.fault_period}) begin
          state_next.fault_step = 8'd0;
        end
      end
    end else begin
      state_next.fault_step = 8'd0;
      priority if (masked == ST_DISABLED || masked == ST_NOT_RDY) begin
        ds = DS_DISABLED;
        cw = CW_SHUTDOWN;
        state_next.enabled_flag = 1'b0;
        state_next.command_reg  = '0;
      end else if (masked == ST_READY) begin
        ds = DS_READY;
        cw = CW_SWITCH_ON;
      end else if (masked == ST_SW_ON) begin
        ds = DS_SW_ON;
        cw = CW_ENABLE_OP;
      end else if (masked == ST_OP_EN) begin
        ds = DS_OP_EN;
        cw = CW_ENABLE_OP;
        // A fresh entry into operation enabled holds zero for one tick.
        if (!state.enabled_flag) begin
          state_next.enabled_flag = 1'b1;
          state_next.command_reg  = '0;
        end else begin
          state_next.command_reg = slewed;
        end
      end else begin
        ds = DS_OTHER;
        cw = CW_SHUTDOWN;
        state_next.enabled_flag = 1'b0;
        state_next.command_reg  = '0;
      end
    end
  end

  assign result.drive_control    = cw;
  assign result.velocity_command = state_next.command_reg;
  assign result.drive_state      = ds;
  assign result.fault_events     = state_next.fault_tally;

endmodule

// ===== hdl/ds402_enable_sequencer_slew_limit_unit.sv =====
// Top level of the drive enable sequencer: input register, sequencer state,
// configuration registers and result register. Depends on ds402_pkg, ds402_step.
//
//   Channel  Signals                                  Direction
//   in       in_valid, in_ready, in_data (in_item_t)   request in
//   out      out_valid, out_ready, out_data (out_item_t) request out
//   cfg      cfg_valid, cfg_ready, cfg_index, cfg_data write in
//
// Requests pass the input register, then the output register; one request is
// taken per cycle unless the output stalls, limited by the single update of
// the sequencer state. Reset (rst, synchronous) empties both registers, clears
// the state and restores the configuration defaults. A stalled result holds in
// the output register while one more request waits in the input register.
module ds402_enable_sequencer_slew_limit_unit import ds402_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic       held_valid;
  in_item_t   held_item;
  seq_state_t state;
  seq_state_t state_next;
  cfg_t       cfg;
  out_item_t  result;
  logic       advance;

  assign advance   = held_valid && (!out_valid || out_ready);
  assign in_ready  = !held_valid || advance;
  assign cfg_ready = 1'b1;

  ds402_step u_step (
    .cfg        (cfg),
    .state      (state),
    .item       (held_item),
    .state_next (state_next),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      out_valid  <= 1'b0;
      state      <= '0;
      cfg.max_step         <= MAX_STEP_RST;
      cfg.reset_pulse_tick <= PULSE_TICK_RST;
      cfg.fault_period     <= FAULT_PER_RST;
    end else begin
      if (in_ready) begin
        held_valid <= in_valid;
      end
      if (advance) begin
        out_valid <= 1'b1;
        state     <= state_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_MAX_STEP:   cfg.max_step         <= cfg_data;
          REG_PULSE_TICK: cfg.reset_pulse_tick <= cfg_data[7:0];
          REG_FAULT_PER:  cfg.fault_period     <= cfg_data[7:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      held_item <= in_data;
    end
    if (advance) begin
      out_data <= result;
    end
  end

endmodule
